@@ hw/rtl/mdt_pkg.sv @@
`default_nettype none

package mdt_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_DIM        = 64;

	localparam int DIM_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	typedef struct packed {
		logic ld_issue;
		logic ld_write;
		logic bk_init;
		logic bk_read;
		logic bk_write;
		logic rd_issue;
		logic rd_step;
	} dp_cmd_t;

	typedef struct packed {
		logic restart;
		logic load_room;
		logic bk_done;
		logic rd_last;
	} dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/mdt_ctrl.sv @@
`default_nettype none

module mdt_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            action,
	input  mdt_pkg::dp_status_t  st,
	output mdt_pkg::dp_cmd_t     cmd,
	output logic                 busy,
	output logic                 done
);
	import mdt_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LD_WR  = 3'd1;
	localparam logic [2:0] S_BK_RD  = 3'd2;
	localparam logic [2:0] S_BK_WR  = 3'd3;
	localparam logic [2:0] S_OUT_RD = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0] state_q, state_d;
	logic       computed_q, computed_d;
	logic       accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_OUT);

	always_comb begin
		state_d    = state_q;
		computed_d = computed_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (st.restart) begin
					computed_d = 1'b0;
				end else if (accept) begin
					if (action == ACT_LOAD) begin
						if (st.load_room && !computed_q) begin
							cmd.ld_issue = 1'b1;
							state_d      = S_LD_WR;
						end
					end else if (computed_q) begin
						cmd.rd_issue = 1'b1;
						state_d      = S_OUT;
					end else begin
						cmd.bk_init = 1'b1;
						state_d     = S_BK_RD;
					end
				end
			end
			S_LD_WR: begin
				cmd.ld_write = 1'b1;
				state_d      = S_IDLE;
			end
			S_BK_RD: begin
				cmd.bk_read = 1'b1;
				state_d     = S_BK_WR;
			end
			S_BK_WR: begin
				cmd.bk_write = 1'b1;
				if (st.bk_done) begin
					computed_d = 1'b1;
					state_d    = S_OUT_RD;
				end else begin
					state_d = S_BK_RD;
				end
			end
			S_OUT_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				cmd.rd_step = 1'b1;
				if (st.rd_last) begin
					computed_d = 1'b0;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			computed_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			computed_q <= computed_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mdt_datapath.sv @@
`default_nettype none

module mdt_datapath #(
	parameter int MAX_WIDTH  = mdt_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mdt_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mdt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mdt_pkg::DIM_W-1:0]     cfg_data,
	input  wire logic                          pixel_bit,
	input  mdt_pkg::dp_cmd_t                   cmd,
	output mdt_pkg::dp_status_t                st,
	output logic [6:0]                         distance,
	output logic                               unreached,
	output logic                               last_of_image
);
	import mdt_pkg::*;

	localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int POS_W  = $clog2(CELLS + 1);
	localparam int WK_W   = $clog2(MAX_WIDTH + MAX_HEIGHT) + 1;
	localparam logic [WK_W-1:0] INF = '1;
	localparam logic [DIM_W-1:0] W_RST = DIM_W'((MAX_WIDTH < DEF_DIM) ? MAX_WIDTH : DEF_DIM);
	localparam logic [DIM_W-1:0] H_RST =
		DIM_W'((MAX_HEIGHT < DEF_DIM) ? MAX_HEIGHT : DEF_DIM);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] x, input int maxv);
		if (x == '0) begin
			return DIM_W'(1);
		end
		if (int'(x) > maxv) begin
			return DIM_W'(maxv);
		end
		return x;
	endfunction

	function automatic logic [WK_W-1:0] sat_inc(input logic [WK_W-1:0] x);
		return (x == INF) ? INF : x + WK_W'(1);
	endfunction

	function automatic logic [WK_W-1:0] min2(input logic [WK_W-1:0] a, input logic [WK_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	logic [DIM_W-1:0]   w_q, h_q;
	logic [2*DIM_W-1:0] area;
	logic [POS_W-1:0]   total;

	logic [POS_W-1:0]   ld_pos_q;
	logic [DIM_W-1:0]   ld_col_q, ld_row_q;
	logic               pix_s1;
	logic               zero_seen_q;
	logic [WK_W-1:0]    prev_q;

	logic [ADDR_W-1:0]  bk_pos_q;
	logic [DIM_W-1:0]   bk_col_q, bk_row_q;

	logic [POS_W-1:0]   rd_pos_q;

	logic [WK_W-1:0]    work_mem [CELLS];
	logic [WK_W-1:0]    rda_q, rdb_q;
	logic [ADDR_W-1:0]  addr_a, addr_w;
	logic               rd_a;
	logic               we;
	logic [WK_W-1:0]    wdata;
	logic [WK_W-1:0]    fwd_d, bk_d;
	logic               cfg_hit;

	assign area  = w_q * h_q;
	assign total = POS_W'(area);

	assign cfg_hit = cfg_we && ((cfg_index == CFG_GRID_WIDTH) || (cfg_index == CFG_GRID_HEIGHT));

	assign st.restart   = cfg_hit;
	assign st.load_room = (ld_pos_q < total);
	assign st.bk_done   = (bk_pos_q == '0);
	assign st.rd_last   = ((rd_pos_q + POS_W'(1)) == total);

	// forward pass on load: up and left neighbors
	always_comb begin
		fwd_d = INF;
		if (ld_row_q != '0) begin
			fwd_d = min2(fwd_d, sat_inc(rda_q));
		end
		if (ld_col_q != '0) begin
			fwd_d = min2(fwd_d, sat_inc(prev_q));
		end
		if (!pix_s1) begin
			fwd_d = '0;
		end
	end

	// backward pass: down and right neighbors
	always_comb begin
		bk_d = rdb_q;
		if ({1'b0, bk_row_q} + (DIM_W+1)'(1) < {1'b0, h_q}) begin
			bk_d = min2(bk_d, sat_inc(rda_q));
		end
		if ({1'b0, bk_col_q} + (DIM_W+1)'(1) < {1'b0, w_q}) begin
			bk_d = min2(bk_d, sat_inc(prev_q));
		end
	end

	always_comb begin
		rd_a   = cmd.ld_issue || cmd.bk_read || cmd.rd_issue;
		addr_a = ADDR_W'(rd_pos_q);
		if (cmd.ld_issue) begin
			addr_a = ADDR_W'(ld_pos_q) - ADDR_W'(w_q);
		end else if (cmd.bk_read) begin
			addr_a = bk_pos_q + ADDR_W'(w_q);
		end
		we     = cmd.ld_write || cmd.bk_write;
		addr_w = cmd.ld_write ? ADDR_W'(ld_pos_q) : bk_pos_q;
		wdata  = cmd.ld_write ? fwd_d : bk_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			work_mem[addr_w] <= wdata;
		end
		if (rd_a) begin
			rda_q <= work_mem[addr_a];
		end
		if (cmd.bk_read) begin
			rdb_q <= work_mem[bk_pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_issue) begin
			pix_s1 <= pixel_bit;
		end
		if (we) begin
			prev_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= W_RST;
			h_q         <= H_RST;
			ld_pos_q    <= '0;
			ld_col_q    <= '0;
			ld_row_q    <= '0;
			zero_seen_q <= 1'b0;
			bk_pos_q    <= '0;
			bk_col_q    <= '0;
			bk_row_q    <= '0;
			rd_pos_q    <= '0;
		end else begin
			if (cfg_hit) begin
				unique case (cfg_index)
					CFG_GRID_WIDTH:  w_q <= clamp_dim(cfg_data, MAX_WIDTH);
					CFG_GRID_HEIGHT: h_q <= clamp_dim(cfg_data, MAX_HEIGHT);
					default: begin
					end
				endcase
				ld_pos_q <= '0;
				ld_col_q <= '0;
				ld_row_q <= '0;
				rd_pos_q <= '0;
			end
			if (cmd.ld_write) begin
				if (ld_pos_q == '0) begin
					zero_seen_q <= !pix_s1;
				end else if (!pix_s1) begin
					zero_seen_q <= 1'b1;
				end
				ld_pos_q <= ld_pos_q + POS_W'(1);
				if (ld_col_q + DIM_W'(1) == w_q) begin
					ld_col_q <= '0;
					ld_row_q <= ld_row_q + DIM_W'(1);
				end else begin
					ld_col_q <= ld_col_q + DIM_W'(1);
				end
			end
			if (cmd.bk_init) begin
				bk_pos_q <= ADDR_W'(total - POS_W'(1));
				bk_col_q <= w_q - DIM_W'(1);
				bk_row_q <= h_q - DIM_W'(1);
				rd_pos_q <= '0;
			end
			if (cmd.bk_write && !st.bk_done) begin
				bk_pos_q <= bk_pos_q - ADDR_W'(1);
				if (bk_col_q == '0) begin
					bk_col_q <= w_q - DIM_W'(1);
					bk_row_q <= bk_row_q - DIM_W'(1);
				end else begin
					bk_col_q <= bk_col_q - DIM_W'(1);
				end
			end
			if (cmd.rd_step) begin
				if (st.rd_last) begin
					rd_pos_q <= '0;
					ld_pos_q <= '0;
					ld_col_q <= '0;
					ld_row_q <= '0;
				end else begin
					rd_pos_q <= rd_pos_q + POS_W'(1);
				end
			end
		end
	end

	assign distance      = !zero_seen_q ? 7'd0 :
	                       (32'(rda_q) > 127) ? 7'd127 : 7'(rda_q);
	assign unreached     = !zero_seen_q;
	assign last_of_image = st.rd_last;

endmodule

`default_nettype wire

@@ hw/rtl/manhattan_distance_transform.sv @@
`default_nettype none

// 4-connected distance transform. Load grid_width*grid_height pixels in raster
// order (action=0), then issue one drain item (action=1) per pixel; each drain
// gives one result with done high for a single cycle, last_of_image on the
// final pixel. The receiver cannot stall, so take every result the cycle
// done is high. A load does one read-modify-write of the work memory for the
// forward pass. The first drain of an image runs the backward pass, a read and
// a write per pixel on the single-write work memory, before it returns its
// result. Writing the grid width or grid height register restarts the frame.
module manhattan_distance_transform #(
	parameter int MAX_WIDTH  = mdt_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mdt_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          action,
	input  wire logic                          pixel_bit,
	output logic                               done,
	output logic [6:0]                         distance,
	output logic                               unreached,
	output logic                               last_of_image,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [mdt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mdt_pkg::DIM_W-1:0]     cfg_data
);
	import mdt_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	assign cfg_ready = !busy;

	mdt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mdt_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixel_bit     (pixel_bit),
		.cmd           (cmd),
		.st            (st),
		.distance      (distance),
		.unreached     (unreached),
		.last_of_image (last_of_image)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a busy item");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_LOAD) |=> !done)
		else $error("load item produced a result");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_unreached_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && unreached) |-> (distance == 7'd0))
		else $error("unreached result carries a distance");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mdt_pkg::*;

	localparam int CELLS     = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
	localparam int FAR_DIST  = 'h100000;
	localparam int SETTLE    = 8;
	localparam int STALL_MAX = 10000;
	localparam int ITEMS     = 700;
	localparam int DIR_ROWS  = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef enum int {FILL_ONES, FILL_ZEROS, FILL_SINGLE, FILL_CORNER, FILL_RANDOM} fill_t;

	typedef struct packed {
		logic [6:0] distance;
		logic       unreached;
		logic       last_flag;
	} dist_result_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [DIM_W-1:0]       data;
		logic                   act;
		logic                   pix;
		logic                   typed;
		dist_result_t           want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 action;
	logic                 pixel_bit;
	logic                 done;
	logic [6:0]           distance;
	logic                 unreached;
	logic                 last_of_image;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	manhattan_distance_transform u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.pixel_bit     (pixel_bit),
		.done          (done),
		.distance      (distance),
		.unreached     (unreached),
		.last_of_image (last_of_image),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// image model
	int   img_w = DEF_DIM;
	int   img_h = DEF_DIM;
	logic pix_mem  [CELLS];
	int   span_mem [CELLS];
	int   dist_mem [CELLS];
	int   load_ptr = 0;
	int   read_ptr = 0;
	bit   dists_ready = 1'b0;
	bit   any_zero = 1'b0;

	dist_result_t distance_q [$];
	int           errors = 0;
	int           counted = 0;
	int           stall_cycles = 0;
	dir_row_t     dir_rows [DIR_ROWS];

	function automatic int fit_dim(input logic [DIM_W-1:0] raw, input int maxv);
		if (raw == '0)
			return 1;
		if (int'(raw) > maxv)
			return maxv;
		return int'(raw);
	endfunction

	function automatic void build_distance_map();
		int w, h, k, d, r, c;
		w = img_w;
		h = img_h;
		any_zero = 1'b0;
		for (r = 0; r < h; r++) begin
			for (c = 0; c < w; c++) begin
				k = r * w + c;
				if (pix_mem[k] == 1'b0) begin
					span_mem[k] = 0;
					any_zero = 1'b1;
				end else begin
					d = FAR_DIST;
					if (r > 0 && span_mem[k - w] + 1 < d)
						d = span_mem[k - w] + 1;
					if (c > 0 && span_mem[k - 1] + 1 < d)
						d = span_mem[k - 1] + 1;
					span_mem[k] = d;
				end
			end
		end
		for (r = h - 1; r >= 0; r--) begin
			for (c = w - 1; c >= 0; c--) begin
				k = r * w + c;
				d = span_mem[k];
				if (r + 1 < h && span_mem[k + w] + 1 < d)
					d = span_mem[k + w] + 1;
				if (c + 1 < w && span_mem[k + 1] + 1 < d)
					d = span_mem[k + 1] + 1;
				span_mem[k] = d;
				dist_mem[k] = (d > 127) ? 127 : d;
			end
		end
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [DIM_W-1:0] val);
		if (idx == CFG_GRID_WIDTH)
			img_w = fit_dim(val, DEF_MAX_WIDTH);
		else if (idx == CFG_GRID_HEIGHT)
			img_h = fit_dim(val, DEF_MAX_HEIGHT);
		else
			return;
		load_ptr = 0;
		read_ptr = 0;
		dists_ready = 1'b0;
	endfunction

	function automatic bit transform_item(input logic act, input logic pix,
		output dist_result_t res);
		int total;
		bit fin;
		total = img_w * img_h;
		res = '0;
		if (act == ACT_LOAD) begin
			if (!dists_ready && load_ptr < total) begin
				pix_mem[load_ptr] = pix;
				load_ptr++;
			end
			return 1'b0;
		end
		if (!dists_ready) begin
			build_distance_map();
			dists_ready = 1'b1;
			read_ptr = 0;
		end
		if (read_ptr >= total)
			read_ptr = total - 1;
		fin = (read_ptr + 1 == total);
		res.distance  = any_zero ? 7'(dist_mem[read_ptr]) : 7'd0;
		res.unreached = !any_zero;
		res.last_flag = fin;
		if (fin) begin
			read_ptr = 0;
			load_ptr = 0;
			dists_ready = 1'b0;
		end else begin
			read_ptr++;
		end
		return 1'b1;
	endfunction

	always @(posedge clk) begin : check_result
		dist_result_t exp_r;
		if (arst_n && done) begin
			if (distance_q.size() == 0) begin
				$error("result with nothing pending: distance=%0d", distance);
				errors++;
			end else begin
				exp_r = distance_q.pop_front();
				if (distance !== exp_r.distance) begin
					$error("distance: expected %0d, got %0d", exp_r.distance, distance);
					errors++;
				end
				if (unreached !== exp_r.unreached) begin
					$error("unreached: expected %0b, got %0b", exp_r.unreached, unreached);
					errors++;
				end
				if (last_of_image !== exp_r.last_flag) begin
					$error("last_of_image: expected %0b, got %0b", exp_r.last_flag,
						last_of_image);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_MAX) begin
			$display("** manhattan_distance_transform: FAILED **");
			$finish;
		end
	end

	task automatic send_item(input logic act, input logic pix, input bit counts);
		int gap, idle_pct;
		bit has;
		dist_result_t r;
		idle_pct = (counted < ITEMS / 3) ? 9 : (counted < 2 * ITEMS / 3) ? 63 : 0;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start     <= 1'b1;
		action    <= act;
		pixel_bit <= pix;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		has = transform_item(act, pix, r);
		if (has)
			distance_q.push_back(r);
		if (counts)
			counted++;
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (distance_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		hold_until_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		apply_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic resize();
		logic [DIM_W-1:0] raw_w, raw_h;
		int r;
		r = $urandom_range(99);
		if (r < 7) begin
			raw_w = (r < 3) ? 7'd64 : 7'($urandom_range(65, 127));
			raw_h = 7'($urandom_range(0, 2));
		end else if (r < 14) begin
			raw_h = (r < 10) ? 7'd64 : 7'($urandom_range(65, 127));
			raw_w = 7'($urandom_range(0, 2));
		end else begin
			raw_w = ($urandom_range(99) < 8) ? 7'd0 : 7'($urandom_range(1, 8));
			raw_h = ($urandom_range(99) < 8) ? 7'd0 : 7'($urandom_range(1, 8));
		end
		if ($urandom_range(1)) begin
			write_reg(CFG_GRID_WIDTH, raw_w);
			write_reg(CFG_GRID_HEIGHT, raw_h);
		end else begin
			write_reg(CFG_GRID_HEIGHT, raw_h);
			write_reg(CFG_GRID_WIDTH, raw_w);
		end
		if ($urandom_range(99) < 15)
			write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 7'($urandom));
	endtask

	function automatic fill_t pick_fill();
		case ($urandom_range(9))
			0: return FILL_ONES;
			1: return FILL_ZEROS;
			2: return FILL_SINGLE;
			3: return FILL_CORNER;
			default: return FILL_RANDOM;
		endcase
	endfunction

	// load one image, then drain it; may restart the frame part way
	task automatic run_frame(input fill_t fill);
		int total, zero_at, pct, cut;
		logic px;
		total = img_w * img_h;
		pct = $urandom_range(5, 60);
		if (fill == FILL_CORNER)
			zero_at = $urandom_range(1) ? 0 : total - 1;
		else
			zero_at = $urandom_range(0, total - 1);
		cut = ($urandom_range(99) < 6) ? $urandom_range(0, total - 1) : -1;
		for (int k = 0; k < total; k++) begin
			if (k == cut) begin
				write_reg($urandom_range(1) ? CFG_GRID_WIDTH : CFG_GRID_HEIGHT,
					7'($urandom_range(1, 8)));
				return;
			end
			case (fill)
				FILL_ONES:   px = 1'b1;
				FILL_ZEROS:  px = 1'b0;
				FILL_RANDOM: px = ($urandom_range(99) >= pct);
				default:     px = (k != zero_at);
			endcase
			send_item(ACT_LOAD, px, 1'b1);
		end
		if ($urandom_range(99) < 10)
			send_item(ACT_LOAD, 1'($urandom), 1'b0);
		cut = ($urandom_range(99) < 5 && total > 1) ? $urandom_range(1, total - 1) : -1;
		for (int k = 0; k < total; k++) begin
			if (k == cut) begin
				write_reg($urandom_range(1) ? CFG_GRID_WIDTH : CFG_GRID_HEIGHT,
					7'($urandom_range(1, 8)));
				return;
			end
			if (k > 0 && $urandom_range(99) < 3)
				send_item(ACT_LOAD, 1'($urandom), 1'b0);
			if (k == total / 2 && $urandom_range(99) < 10)
				hold_until_drained();
			send_item(ACT_DRAIN, 1'($urandom), 1'b1);
		end
	endtask

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [DIM_W-1:0] val);
		dir_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.idx  = idx;
		row.data = val;
		return row;
	endfunction

	function automatic dir_row_t item_row(input logic act, input logic pix);
		dir_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.act  = act;
		row.pix  = pix;
		return row;
	endfunction

	function automatic dir_row_t check_row(input logic [6:0] d, input logic u, input logic l);
		dir_row_t row;
		row = item_row(ACT_DRAIN, 1'b1);
		row.typed = 1'b1;
		row.want.distance  = d;
		row.want.unreached = u;
		row.want.last_flag = l;
		return row;
	endfunction

	initial begin
		start     = 1'b0;
		action    = ACT_LOAD;
		pixel_bit = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_GRID_WIDTH;
		cfg_data  = '0;
		arst_n    = 1'b0;
		for (int k = 0; k < CELLS; k++) begin
			pix_mem[k]  = 1'b0;
			dist_mem[k] = 0;
		end

		dir_rows = '{
			cfg_row(CFG_GRID_WIDTH, 7'd0),
			cfg_row(CFG_GRID_HEIGHT, 7'd0),
			item_row(ACT_LOAD, 1'b1),
			check_row(7'd0, 1'b1, 1'b1),
			item_row(ACT_LOAD, 1'b0),
			check_row(7'd0, 1'b0, 1'b1),
			cfg_row(CFG_GRID_WIDTH, 7'd3),
			cfg_row(CFG_GRID_HEIGHT, 7'd2),
			item_row(ACT_LOAD, 1'b1),
			item_row(ACT_LOAD, 1'b1),
			item_row(ACT_LOAD, 1'b1),
			cfg_row(CFG_SPARE_A, 7'h55),
			cfg_row(CFG_SPARE_B, 7'h2A),
			item_row(ACT_LOAD, 1'b1),
			item_row(ACT_LOAD, 1'b1),
			item_row(ACT_LOAD, 1'b0),
			item_row(ACT_LOAD, 1'b0),
			check_row(7'd3, 1'b0, 1'b0),
			check_row(7'd2, 1'b0, 1'b0),
			item_row(ACT_LOAD, 1'b1),
			check_row(7'd1, 1'b0, 1'b0),
			item_row(ACT_DRAIN, 1'b0),
			item_row(ACT_DRAIN, 1'b1),
			check_row(7'd0, 1'b0, 1'b1)
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_item(dir_rows[i].act, dir_rows[i].pix, 1'b0);
				if (dir_rows[i].typed)
					distance_q[distance_q.size() - 1] = dir_rows[i].want;
			end
		end
		hold_until_drained();

		// long rows and columns with a zero in a corner reach the top distance bit
		write_reg(CFG_GRID_WIDTH, 7'd127);
		write_reg(CFG_GRID_HEIGHT, 7'd2);
		run_frame(FILL_CORNER);
		write_reg(CFG_GRID_WIDTH, 7'd2);
		write_reg(CFG_GRID_HEIGHT, 7'd100);
		run_frame(FILL_CORNER);

		while (counted < ITEMS) begin
			if ($urandom_range(99) < 55)
				resize();
			run_frame(pick_fill());
		end

		hold_until_drained();
		if (errors == 0)
			$display("** manhattan_distance_transform: PASSED **");
		else
			$display("** manhattan_distance_transform: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/mdt_pkg.sv
hw/rtl/mdt_ctrl.sv
hw/rtl/mdt_datapath.sv
hw/rtl/manhattan_distance_transform.sv
verif/tb.sv
